/* rtl/tzf_pkg.sv */
// ----------------------------------------------------------------------------
// tzf_pkg
// Shared types, codes and constants of the thermal zone fan speed controller.
// ----------------------------------------------------------------------------
package tzf_pkg;

   localparam int TEMP_W    = 19;
   localparam int LIMIT_W   = 18;
   localparam int SPEED_W   = 7;
   localparam int NRANGES   = 5;
   localparam int ENTRY_W   = 2 * LIMIT_W;

   localparam logic [SPEED_W-1:0] FULL_SPEED = 7'd100;

   // percent scale factors, 16 fraction bits, rounded up
   localparam logic [16:0] MUL_09 = 17'd58983;
   localparam logic [16:0] MUL_11 = 17'd72090;
   localparam logic [16:0] MUL_12 = 17'd78644;

   localparam logic [1:0] MODE_READING = 2'd0;
   localparam logic [1:0] MODE_FAN     = 2'd1;
   localparam logic [1:0] MODE_PERIOD  = 2'd2;
   localparam logic [1:0] MODE_LIMIT   = 2'd3;

   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_HOLDOFF  = 2'd1;
   localparam logic [1:0] CSR_MINSPEED = 2'd2;
   localparam logic [1:0] CSR_RISE     = 2'd3;

   localparam logic [2:0] ZONE_LOW     = 3'd0;
   localparam logic [2:0] ZONE_DESIRED = 3'd1;
   localparam logic [2:0] ZONE_HIGH    = 3'd2;
   localparam logic [2:0] ZONE_VHIGH   = 3'd3;
   localparam logic [2:0] ZONE_CRIT    = 3'd4;

   localparam logic [3:0] LIMIT_IDX_MAX = 4'd9;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         zone;
      logic [7:0]         hold;
      logic [SPEED_W-1:0] present_speed;
      logic [SPEED_W-1:0] min_speed;
      logic               rise_seen;
      logic               shutdown_state;
   } period_in_type;

   typedef struct packed {
      logic               update;
      logic [SPEED_W-1:0] speed;
   } period_out_type;

   typedef struct packed {
      logic               speed_update;
      logic [SPEED_W-1:0] new_speed;
      logic               shutdown_request;
      logic [2:0]         zone;
   } result_type;

   // floor(p * factor), factor in 1.16 fixed point
   function automatic logic [7:0] scale(input logic [SPEED_W-1:0] p,
                                        input logic [16:0] mul);
      logic [23:0] prod;
      prod = {17'd0, p} * {7'd0, mul};
      return prod[23:16];
   endfunction

endpackage

/* rtl/tzf_req_if.sv */
// ----------------------------------------------------------------------------
// tzf_req_if / tzf_rsp_if
// Item channels of the thermal zone fan speed controller.
// ----------------------------------------------------------------------------
interface tzf_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic [3:0]                          sensor_index;
   logic signed [tzf_pkg::TEMP_W-1:0]   temperature;
   logic                                reading_valid;
   logic [tzf_pkg::LIMIT_W-1:0]         shutdown_limit;
   logic                                fan_present;
   logic                                fan_rpm_ok;
   logic                                shutdown_state;
   logic [tzf_pkg::SPEED_W-1:0]         present_speed;
   logic [3:0]                          limit_index;
   logic [tzf_pkg::LIMIT_W-1:0]         limit_value;

   modport source (output valid, mode, sensor_index, temperature, reading_valid,
                   shutdown_limit, fan_present, fan_rpm_ok, shutdown_state,
                   present_speed, limit_index, limit_value, input ready);
   modport sink (input valid, mode, sensor_index, temperature, reading_valid,
                 shutdown_limit, fan_present, fan_rpm_ok, shutdown_state,
                 present_speed, limit_index, limit_value, output ready);
endinterface

interface tzf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        speed_update;
   logic [tzf_pkg::SPEED_W-1:0] new_speed;
   logic                        shutdown_request;
   logic [2:0]                  zone;

   modport source (output valid, speed_update, new_speed, shutdown_request, zone,
                   input ready);
   modport sink (input valid, speed_update, new_speed, shutdown_request, zone,
                 output ready);
endinterface

/* rtl/tzf_speed_rule.sv */
// ----------------------------------------------------------------------------
// tzf_speed_rule
// Period-end speed rule: picks the new fan speed for the zone in force.
// ----------------------------------------------------------------------------
module tzf_speed_rule (
   input  tzf_pkg::period_in_type  rule_in,
   output tzf_pkg::period_out_type rule_out
);

   logic       upd;
   logic [7:0] spd;

   always_comb begin
      upd = 1'b0;
      spd = 8'd0;
      case (rule_in.zone)
         tzf_pkg::ZONE_LOW: begin
            if (rule_in.hold == 8'd0 && rule_in.min_speed < rule_in.present_speed) begin
               spd = tzf_pkg::scale(rule_in.present_speed, tzf_pkg::MUL_09);
               upd = 1'b1;
            end
         end
         tzf_pkg::ZONE_HIGH: begin
            if (rule_in.present_speed < rule_in.min_speed) begin
               spd = {1'b0, rule_in.min_speed};
               upd = 1'b1;
            end
         end
         tzf_pkg::ZONE_VHIGH: begin
            if (rule_in.present_speed < tzf_pkg::FULL_SPEED) begin
               if (rule_in.rise_seen) begin
                  spd = tzf_pkg::scale(rule_in.present_speed, tzf_pkg::MUL_12);
                  upd = 1'b1;
               end else if (rule_in.hold == 8'd0) begin
                  spd = tzf_pkg::scale(rule_in.present_speed, tzf_pkg::MUL_11);
                  upd = 1'b1;
               end
            end
         end
         tzf_pkg::ZONE_CRIT: begin
            if (rule_in.shutdown_state || rule_in.present_speed < tzf_pkg::FULL_SPEED) begin
               spd = {1'b0, tzf_pkg::FULL_SPEED};
               upd = 1'b1;
            end
         end
         default: begin
            upd = 1'b0;
         end
      endcase
      // saturate at full speed
      if (spd > {1'b0, tzf_pkg::FULL_SPEED}) begin
         spd = {1'b0, tzf_pkg::FULL_SPEED};
      end
      rule_out.update = upd;
      rule_out.speed  = spd[tzf_pkg::SPEED_W-1:0];
   end

endmodule

/* rtl/thermal_zone_fan_speed_controller.sv */
// ----------------------------------------------------------------------------
// thermal_zone_fan_speed_controller
// Thermal zone classification and fan speed control, one result per item.
// ----------------------------------------------------------------------------
// Items are handled one at a time. The range table is a synchronous memory
// and a reading's scan reads one range entry per cycle, critical first,
// stopping at the first match (up to five reads). A range limit load reads
// the entry, merges the new limit and writes it back into the 36-bit entry;
// fan status, period end, failed or out-of-range items go straight to the
// result register. The next item is accepted as soon as the result sits in
// the output register, even if the consumer has not yet taken it. After
// reset a clearing pass zeroes the range table and the reading banks; no
// item is accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
module thermal_zone_fan_speed_controller #(
   parameter int SENSORS = 16
) (
   input  logic          clock,
   input  logic          reset,
   tzf_req_if.sink       req_chan,
   tzf_rsp_if.source     rsp_chan,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam int SW         = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int RD         = SENSORS * tzf_pkg::NRANGES;   // range entries
   localparam int RAW        = $clog2(RD);
   localparam int BAW        = SW + 1;                       // bank bit + sensor
   localparam int BANK_DEPTH = 2 ** BAW;

   localparam int TW = tzf_pkg::TEMP_W;
   localparam int LW = tzf_pkg::LIMIT_W;
   localparam int EW = tzf_pkg::ENTRY_W;

   // configuration
   logic        enable_ff;
   logic [7:0]  holdoff_periods_ff;
   logic [6:0]  min_speed_ff;
   logic [15:0] rise_delta_ff;

   // control and per-period state
   tzf_pkg::state_type state_ff, state_in;
   logic [RAW-1:0]     clr_ff, clr_in;
   logic               baseline_ff, baseline_in;
   logic [2:0]         worst_ff, worst_in;
   logic               fault_ff, fault_in;
   logic               rise_ff, rise_in;
   logic [7:0]         hold_ff, hold_in;
   logic               out_valid_ff, out_valid_in;

   // item registers
   logic signed [TW-1:0] temp_ff, temp_in;
   logic [LW-1:0]        lim_ff, lim_in;
   logic [2:0]           r_ff, r_in;
   logic [RAW-1:0]       base_ff, base_in;    // entry address of range 0 or target
   logic                 merge_hi_ff, merge_hi_in;
   logic [LW-1:0]        lval_ff, lval_in;
   tzf_pkg::result_type  res_ff, res_in;
   tzf_pkg::result_type  out_ff, out_in;

   // memories: range entry is {high, low}
   logic [EW-1:0] range_mem [RD];
   logic [EW-1:0] range_rd_ff;
   logic [TW-1:0] bank_mem [BANK_DEPTH];
   logic [TW-1:0] bank_rd_ff;

   logic           rng_re, rng_we;
   logic [RAW-1:0] rng_raddr, rng_waddr;
   logic [EW-1:0]  rng_wdata;
   logic           bank_re, bank_we;
   logic [BAW-1:0] bank_raddr, bank_waddr;
   logic [TW-1:0]  bank_wdata;

   // period-end rule
   tzf_pkg::period_in_type  rule_in;
   tzf_pkg::period_out_type rule_out;

   tzf_speed_rule u_rule (
      .rule_in  (rule_in),
      .rule_out (rule_out)
   );

   // request decode
   logic [SW-1:0]  s_idx;
   logic           s_ok;
   logic [RAW-1:0] s_base;
   logic [7:0]     hold_dec;
   logic [2:0]     period_zone;

   assign s_idx       = SW'(req_chan.sensor_index);
   assign s_ok        = int'(req_chan.sensor_index) < SENSORS;
   assign s_base      = RAW'({s_idx, 2'b00}) + RAW'(s_idx);   // sensor * 5
   assign hold_dec    = (hold_ff != 8'd0) ? hold_ff - 8'd1 : 8'd0;
   assign period_zone = (req_chan.shutdown_state || fault_ff) ? tzf_pkg::ZONE_CRIT : worst_ff;

   always_comb begin
      rule_in.zone           = period_zone;
      rule_in.hold           = hold_dec;
      rule_in.present_speed  = req_chan.present_speed;
      rule_in.min_speed      = min_speed_ff;
      rule_in.rise_seen      = rise_ff;
      rule_in.shutdown_state = req_chan.shutdown_state;
   end

   // scan evaluation against the entry read last cycle
   logic [LW-1:0]        ent_lo, ent_hi;
   logic signed [LW+1:0] t_x, lo_x, hi_x;
   logic                 hit;
   logic signed [TW+1:0] rise_diff;
   logic                 rise_hit, shreq;

   assign ent_lo    = range_rd_ff[LW-1:0];
   assign ent_hi    = range_rd_ff[EW-1:LW];
   assign t_x       = (LW+2)'(temp_ff);
   assign lo_x      = $signed({2'b00, ent_lo});
   assign hi_x      = $signed({2'b00, ent_hi});
   assign hit       = (ent_hi > ent_lo) && (t_x < hi_x) && ((r_ff == 3'd0) || (lo_x < t_x));
   assign rise_diff = (TW+2)'(temp_ff) - (TW+2)'($signed(bank_rd_ff));
   assign rise_hit  = rise_diff > $signed({5'd0, rise_delta_ff});
   assign shreq     = (lim_ff != '0) && (t_x > $signed({2'b00, lim_ff}));

   logic out_free;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      baseline_in  = baseline_ff;
      worst_in     = worst_ff;
      fault_in     = fault_ff;
      rise_in      = rise_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      temp_in      = temp_ff;
      lim_in       = lim_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      merge_hi_in  = merge_hi_ff;
      lval_in      = lval_ff;
      res_in       = res_ff;
      out_in       = out_ff;

      rng_re     = 1'b0;
      rng_raddr  = base_ff;
      rng_we     = 1'b0;
      rng_waddr  = base_ff;
      rng_wdata  = '0;
      bank_re    = 1'b0;
      bank_raddr = {baseline_ff, s_idx};
      bank_we    = 1'b0;
      bank_waddr = {~baseline_ff, s_idx};
      bank_wdata = '0;

      req_chan.ready = 1'b0;

      case (state_ff)
         tzf_pkg::ST_CLEAR: begin
            rng_we    = 1'b1;
            rng_waddr = clr_ff;
            bank_we    = int'(clr_ff) < BANK_DEPTH;
            bank_waddr = clr_ff[BAW-1:0];
            clr_in    = clr_ff + RAW'(1);
            if (int'(clr_ff) == RD - 1) begin
               state_in = tzf_pkg::ST_IDLE;
            end
         end
         tzf_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_in   = '0;
               temp_in  = req_chan.temperature;
               lim_in   = req_chan.shutdown_limit;
               base_in  = s_base;
               state_in = tzf_pkg::ST_DONE;
               case (req_chan.mode)
                  tzf_pkg::MODE_READING: begin
                     if (s_ok) begin
                        bank_we    = 1'b1;
                        bank_wdata = req_chan.reading_valid ? req_chan.temperature : '0;
                        if (req_chan.reading_valid) begin
                           bank_re   = 1'b1;
                           rng_re    = 1'b1;
                           rng_raddr = s_base + RAW'(tzf_pkg::NRANGES - 1);
                           r_in      = 3'(tzf_pkg::NRANGES - 1);
                           state_in  = tzf_pkg::ST_SCAN;
                        end
                     end
                  end
                  tzf_pkg::MODE_FAN: begin
                     if (!req_chan.fan_present || !req_chan.fan_rpm_ok) begin
                        fault_in = 1'b1;
                     end
                  end
                  tzf_pkg::MODE_PERIOD: begin
                     if (enable_ff) begin
                        hold_in                 = rule_out.update ? holdoff_periods_ff : hold_dec;
                        baseline_in             = baseline_ff ^ rule_out.update;
                        res_in.speed_update     = rule_out.update;
                        res_in.new_speed        = rule_out.speed;
                        res_in.zone             = period_zone;
                     end
                     worst_in = tzf_pkg::ZONE_LOW;
                     fault_in = 1'b0;
                     rise_in  = 1'b0;
                  end
                  tzf_pkg::MODE_LIMIT: begin
                     if (s_ok && req_chan.limit_index <= tzf_pkg::LIMIT_IDX_MAX) begin
                        rng_re      = 1'b1;
                        rng_raddr   = s_base + RAW'(req_chan.limit_index[3:1]);
                        base_in     = s_base + RAW'(req_chan.limit_index[3:1]);
                        merge_hi_in = req_chan.limit_index[0];
                        lval_in     = req_chan.limit_value;
                        state_in    = tzf_pkg::ST_MERGE;
                     end
                  end
                  default: begin
                     state_in = tzf_pkg::ST_DONE;
                  end
               endcase
            end
         end
         tzf_pkg::ST_SCAN: begin
            if (hit || r_ff == 3'd0) begin
               // first match from critical down raises the period's worst zone
               if (hit && r_ff > worst_ff) begin
                  worst_in = r_ff;
               end
               if (rise_hit) begin
                  rise_in = 1'b1;
               end
               res_in.shutdown_request = shreq;
               state_in = tzf_pkg::ST_DONE;
            end else begin
               rng_re    = 1'b1;
               rng_raddr = base_ff + RAW'(r_ff - 3'd1);
               r_in      = r_ff - 3'd1;
            end
         end
         tzf_pkg::ST_MERGE: begin
            rng_we    = 1'b1;
            rng_waddr = base_ff;
            rng_wdata = merge_hi_ff ? {lval_ff, ent_lo} : {ent_hi, lval_ff};
            state_in  = tzf_pkg::ST_DONE;
         end
         tzf_pkg::ST_DONE: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = tzf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tzf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tzf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         baseline_ff  <= 1'b0;
         worst_ff     <= tzf_pkg::ZONE_LOW;
         fault_ff     <= 1'b0;
         rise_ff      <= 1'b0;
         hold_ff      <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         baseline_ff  <= baseline_in;
         worst_ff     <= worst_in;
         fault_ff     <= fault_in;
         rise_ff      <= rise_in;
         hold_ff      <= hold_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff     <= temp_in;
      lim_ff      <= lim_in;
      r_ff        <= r_in;
      base_ff     <= base_in;
      merge_hi_ff <= merge_hi_in;
      lval_ff     <= lval_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff          <= 1'b0;
         holdoff_periods_ff <= 8'd30;
         min_speed_ff       <= 7'd60;
         rise_delta_ff      <= 16'd4000;
      end else if (csr_we) begin
         case (csr_index)
            tzf_pkg::CSR_ENABLE:   enable_ff          <= csr_wdata[0];
            tzf_pkg::CSR_HOLDOFF:  holdoff_periods_ff <= csr_wdata[7:0];
            tzf_pkg::CSR_MINSPEED: min_speed_ff       <= csr_wdata[6:0];
            tzf_pkg::CSR_RISE:     rise_delta_ff      <= csr_wdata;
            default: begin
               enable_ff <= enable_ff;
            end
         endcase
      end
   end

   // range table
   always_ff @(posedge clock) begin
      if (rng_we) begin
         range_mem[rng_waddr] <= rng_wdata;
      end
      if (rng_re) begin
         range_rd_ff <= range_mem[rng_raddr];
      end
   end

   // reading banks
   always_ff @(posedge clock) begin
      if (bank_we) begin
         bank_mem[bank_waddr] <= bank_wdata;
      end
      if (bank_re) begin
         bank_rd_ff <= bank_mem[bank_raddr];
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.speed_update     = out_ff.speed_update;
   assign rsp_chan.new_speed        = out_ff.new_speed;
   assign rsp_chan.shutdown_request = out_ff.shutdown_request;
   assign rsp_chan.zone             = out_ff.zone;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == tzf_pkg::ST_CLEAR |-> !req_chan.ready)
      else $error("item taken during clearing pass");

   a_idle_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.speed_update |-> rsp_chan.new_speed == '0)
      else $error("speed set without update");

   a_speed_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.new_speed <= tzf_pkg::FULL_SPEED)
      else $error("speed above full");

   a_period_clears: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.mode == tzf_pkg::MODE_PERIOD
      |=> worst_ff == tzf_pkg::ZONE_LOW && !fault_ff && !rise_ff)
      else $error("period values not cleared");
`endif

endmodule
